### design/ow_pkg.sv
`default_nettype none

package ow_pkg;

    // Width of the slot and phase timer
    localparam int TIMER_BITS = 10;

    // Largest count of the timer, held wide enough for timer widths up to 17 bits
    localparam logic [16:0] TICK_MAX = 17'((1 << TIMER_BITS) - 1);

    typedef logic [TIMER_BITS-1:0] ow_tick_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } ow_action_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_RLOW  = 3'd1,
        PH_WAIT  = 3'd2,
        PH_WIN   = 3'd3,
        PH_WRITE = 3'd4,
        PH_READ  = 3'd5
    } ow_phase_t;

    typedef enum logic [2:0] {
        CFG_RESET_LOW      = 3'd0,
        CFG_PRESENCE_WAIT  = 3'd1,
        CFG_PRESENCE_WIN   = 3'd2,
        CFG_WRITE_ONE_LOW  = 3'd3,
        CFG_WRITE_ZERO_LOW = 3'd4,
        CFG_SLOT           = 3'd5,
        CFG_READ_LOW       = 3'd6,
        CFG_READ_SAMPLE    = 3'd7
    } ow_cfg_idx_t;

    // Timing values already clipped to the timer range
    typedef struct packed {
        ow_tick_t reset_low;
        ow_tick_t presence_wait;
        ow_tick_t presence_window;
        ow_tick_t write_one_low;
        ow_tick_t write_zero_low;
        ow_tick_t slot;
        ow_tick_t read_low;
        ow_tick_t read_sample;
    } ow_timing_t;

    // One result beat
    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       present;
        logic [7:0] read_data;
    } ow_result_t;

    // Clip a register value to the largest timer count
    function automatic ow_tick_t clip_timer(input logic [9:0] v);
        logic [16:0] wide;
        wide = 17'(v);
        if (wide > TICK_MAX)
        begin
            wide = TICK_MAX;
        end
        return wide[TIMER_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

### design/ow_cfg_regs.sv
`default_nettype none

module ow_cfg_regs (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [9:0]          cfg_data,
    output ow_pkg::ow_timing_t       timing
);
    import ow_pkg::*;

    logic [9:0] reset_low_reg;
    logic [7:0] presence_wait_reg;
    logic [9:0] presence_window_reg;
    logic [5:0] write_one_low_reg;
    logic [7:0] write_zero_low_reg;
    logic [7:0] slot_reg;
    logic [3:0] read_low_reg;
    logic [5:0] read_sample_reg;

    ow_tick_t slot_clip;
    ow_tick_t sample_clip;

    // Take register writes, masked to each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_reg       <= 10'd497;
            presence_wait_reg   <= 8'd61;
            presence_window_reg <= 10'd480;
            write_one_low_reg   <= 6'd10;
            write_zero_low_reg  <= 8'd80;
            slot_reg            <= 8'd90;
            read_low_reg        <= 4'd1;
            read_sample_reg     <= 6'd10;
        end
        else if (cfg_we)
        begin
            unique case (ow_cfg_idx_t'(cfg_index))
                CFG_RESET_LOW:      reset_low_reg       <= cfg_data;
                CFG_PRESENCE_WAIT:  presence_wait_reg   <= cfg_data[7:0];
                CFG_PRESENCE_WIN:   presence_window_reg <= cfg_data;
                CFG_WRITE_ONE_LOW:  write_one_low_reg   <= cfg_data[5:0];
                CFG_WRITE_ZERO_LOW: write_zero_low_reg  <= cfg_data[7:0];
                CFG_SLOT:           slot_reg            <= cfg_data[7:0];
                CFG_READ_LOW:       read_low_reg        <= cfg_data[3:0];
                CFG_READ_SAMPLE:    read_sample_reg     <= cfg_data[5:0];
                default:            ;
            endcase
        end
    end

    // Clip slot length, treat a zero slot as one tick, pull a late sample point in
    always_comb
    begin
        slot_clip = clip_timer(10'(slot_reg));
        if (slot_clip == '0)
        begin
            slot_clip = ow_tick_t'(1);
        end
        sample_clip = clip_timer(10'(read_sample_reg));
        if (sample_clip >= slot_clip)
        begin
            sample_clip = slot_clip - ow_tick_t'(1);
        end
    end

    assign timing.reset_low       = clip_timer(reset_low_reg);
    assign timing.presence_wait   = clip_timer(10'(presence_wait_reg));
    assign timing.presence_window = clip_timer(presence_window_reg);
    assign timing.write_one_low   = clip_timer(10'(write_one_low_reg));
    assign timing.write_zero_low  = clip_timer(10'(write_zero_low_reg));
    assign timing.slot            = slot_clip;
    assign timing.read_low        = clip_timer(10'(read_low_reg));
    assign timing.read_sample     = sample_clip;

endmodule

`default_nettype wire

### design/ow_seq.sv
`default_nettype none

module ow_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [1:0]          action,
    input  wire logic [7:0]          data_byte,
    input  wire logic                bus_level,
    input  wire ow_pkg::ow_timing_t  timing,
    output ow_pkg::ow_result_t       result
);
    import ow_pkg::*;

    localparam int TW = TIMER_BITS;

    ow_phase_t  phase_reg, phase_next;
    ow_tick_t   tick_reg, tick_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic       presence_reg, presence_next;
    logic [7:0] last_read_reg, last_read_next;

    // Values after a command start and after zero-length stages fall through
    ow_phase_t  ph_start, ph_act;
    ow_tick_t   tc_start, tc_act;
    logic [2:0] bit_start;
    logic [7:0] shift_start;
    logic       presence_start;

    logic          start;
    logic [TW:0]   tc_inc;
    logic [TW:0]   tc_win;
    logic          win_live;
    logic          win_end;
    logic          slot_end;
    logic          sample_hit;
    logic [7:0]    shift_sampled;
    ow_tick_t      write_low;

    assign start = (phase_reg == PH_IDLE) && (ow_action_t'(action) != ACT_TICK);

    // Resolve the command start and skip stages whose count is already reached
    always_comb
    begin
        ph_start       = phase_reg;
        tc_start       = tick_reg;
        bit_start      = bit_reg;
        shift_start    = shift_reg;
        presence_start = presence_reg;
        if (start)
        begin
            tc_start  = '0;
            bit_start = '0;
            unique case (ow_action_t'(action))
                ACT_RESET:
                begin
                    presence_start = 1'b0;
                    ph_start       = PH_RLOW;
                end
                ACT_WRITE:
                begin
                    shift_start = data_byte;
                    ph_start    = PH_WRITE;
                end
                default:
                begin
                    shift_start = 8'h00;
                    ph_start    = PH_READ;
                end
            endcase
        end

        ph_act = ph_start;
        tc_act = tc_start;
        if (ph_act == PH_RLOW && tc_act >= timing.reset_low)
        begin
            ph_act = PH_WAIT;
            tc_act = '0;
        end
        if (ph_act == PH_WAIT && tc_act >= timing.presence_wait)
        begin
            ph_act = PH_WIN;
            tc_act = '0;
        end
    end

    // Shared counts and slot events
    assign tc_inc        = {1'b0, tc_act} + {{TW{1'b0}}, 1'b1};
    assign win_live      = tc_act < timing.presence_window;
    assign tc_win        = win_live ? tc_inc : {1'b0, tc_act};
    assign win_end       = tc_win >= {1'b0, timing.presence_window};
    assign slot_end      = tc_inc >= {1'b0, timing.slot};
    assign sample_hit    = tc_act == timing.read_sample;
    assign shift_sampled = sample_hit ? {bus_level, shift_start[7:1]} : shift_start;
    assign write_low     = shift_start[0] ? timing.write_one_low : timing.write_zero_low;

    // Next state
    always_comb
    begin
        phase_next     = ph_act;
        tick_next      = tc_act;
        bit_next       = bit_start;
        shift_next     = shift_start;
        presence_next  = presence_start;
        last_read_next = last_read_reg;
        unique case (ph_act)
            PH_IDLE: ;
            PH_RLOW, PH_WAIT:
            begin
                tick_next = tc_inc[TW-1:0];
            end
            PH_WIN:
            begin
                if (win_live && !bus_level)
                begin
                    presence_next = 1'b1;
                end
                tick_next = tc_win[TW-1:0];
                if (win_end)
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            end
            PH_WRITE:
            begin
                tick_next = tc_inc[TW-1:0];
                if (slot_end)
                begin
                    tick_next  = '0;
                    shift_next = {1'b0, shift_start[7:1]};
                    bit_next   = bit_start + 3'd1;
                    if (bit_start == 3'd7)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_READ:
            begin
                tick_next  = tc_inc[TW-1:0];
                shift_next = shift_sampled;
                if (slot_end)
                begin
                    tick_next = '0;
                    bit_next  = bit_start + 3'd1;
                    if (bit_start == 3'd7)
                    begin
                        last_read_next = shift_sampled;
                        phase_next     = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Outputs for this tick
    always_comb
    begin
        result.drive_low = 1'b0;
        result.done      = 1'b0;
        unique case (ph_act)
            PH_RLOW:  result.drive_low = 1'b1;
            PH_WIN:   result.done      = win_end;
            PH_WRITE:
            begin
                result.drive_low = tc_act < write_low;
                result.done      = slot_end && (bit_start == 3'd7);
            end
            PH_READ:
            begin
                result.drive_low = tc_act < timing.read_low;
                result.done      = slot_end && (bit_start == 3'd7);
            end
            default: ;
        endcase
        result.busy      = ph_start != PH_IDLE;
        result.present   = presence_next;
        result.read_data = last_read_next;
    end

    // Advance the sequencer once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            presence_reg  <= 1'b0;
            last_read_reg <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            presence_reg  <= presence_next;
            last_read_reg <= last_read_next;
        end
    end

    // A completed command leaves the sequencer idle
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.done |=> phase_reg == PH_IDLE)
        else $error("sequencer not idle after done");

    // The line is only pulled low while a command runs
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.drive_low |-> result.busy)
        else $error("drive low outside a command");

    // The timer and bit count are cleared whenever the sequencer is idle
    a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> tick_reg == '0 && bit_reg == 3'd0)
        else $error("timer or bit count not cleared in idle");

endmodule

`default_nettype wire

### design/one_wire_bus_master_top.sv
`default_nettype none

// One-wire bus master, one input beat per bus tick.
// The result beat for a tick is registered and presented in the cycle after the tick is accepted.
// Throughput: one tick per cycle while the result channel is not stalled; the sequencer steps once per accepted beat.
// A stalled result beat holds in_ready low; a new tick is taken as the result drains.
// Reset: sequencer idle, counters and bytes zero, timing registers at their defaults.
module one_wire_bus_master_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [9:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] action,
    input  wire logic [7:0] data_byte,
    input  wire logic       bus_level,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            drive_low,
    output logic            busy_res,
    output logic            done_res,
    output logic            device_present,
    output logic [7:0]      read_data
);
    import ow_pkg::*;

    ow_timing_t timing;
    ow_result_t result;
    ow_result_t res_reg;
    logic       out_valid_reg, out_valid_next;
    logic       in_accept;

    ow_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    ow_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_accept),
        .action    (action),
        .data_byte (data_byte),
        .bus_level (bus_level),
        .timing    (timing),
        .result    (result)
    );

    // Take a beat when the output register is empty or draining
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_low      = res_reg.drive_low;
    assign busy_res       = res_reg.busy;
    assign done_res       = res_reg.done;
    assign device_present = res_reg.present;
    assign read_data      = res_reg.read_data;

    // Every accepted tick produces a pending result beat
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted tick without result beat");

endmodule

`default_nettype wire

### dv/ow_bus_checker.sv
module ow_bus_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [9:0]       cfg_data,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [1:0]       action,
    input  logic [7:0]       data_byte,
    input  logic             bus_level,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic             drive_low,
    input  logic             busy_res,
    input  logic             done_res,
    input  logic             device_present,
    input  logic [7:0]       read_data,
    output int unsigned      fail_count,
    output int unsigned      backlog,
    output logic             seq_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    import ow_pkg::*;

    // Timing registers as last written
    logic [9:0] t_reset_low;
    logic [9:0] t_pres_wait;
    logic [9:0] t_pres_win;
    logic [9:0] t_one_low;
    logic [9:0] t_zero_low;
    logic [9:0] t_slot;
    logic [9:0] t_read_low;
    logic [9:0] t_read_samp;

    // Sequencer state of the predicted bus master
    ow_phase_t   seq_phase;
    int unsigned slot_pos;
    int unsigned bit_pos;
    logic [7:0]  shifter;
    logic        presence_flag;
    logic [7:0]  last_byte;

    ow_result_t  expected_beats[$];

    initial
    begin
        fail_count = 0;
        backlog    = 0;
        seq_idle   = 1'b1;
    end

    // Limit a timing value to the largest timer count
    function automatic int unsigned timer_cap(input logic [9:0] v);
        if ({7'd0, v} > TICK_MAX)
        begin
            return int'(TICK_MAX);
        end
        return int'(v);
    endfunction

    // Advance the bus master by one tick and produce its result beat
    task automatic step_bus_tick(input ow_action_t act, input logic [7:0] dat,
                                 input logic lvl, output ow_result_t res);
        int unsigned slot_len;
        int unsigned samp;
        int unsigned low_len;
        logic        again;
        res = '0;
        slot_len = timer_cap(t_slot);
        if (slot_len == 0)
        begin
            slot_len = 1;
        end

        // Take a new command only while idle
        if (seq_phase == PH_IDLE && act != ACT_TICK)
        begin
            slot_pos = 0;
            bit_pos  = 0;
            case (act)
                ACT_RESET:
                begin
                    presence_flag = 1'b0;
                    seq_phase     = PH_RLOW;
                end
                ACT_WRITE:
                begin
                    shifter   = dat;
                    seq_phase = PH_WRITE;
                end
                default:
                begin
                    shifter   = 8'd0;
                    seq_phase = PH_READ;
                end
            endcase
        end
        res.busy = (seq_phase != PH_IDLE);

        // Zero-length reset stages fall through within the same tick
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (seq_phase)
                PH_RLOW:
                begin
                    if (slot_pos < timer_cap(t_reset_low))
                    begin
                        res.drive_low = 1'b1;
                        slot_pos++;
                    end
                    else
                    begin
                        seq_phase = PH_WAIT;
                        slot_pos  = 0;
                        again     = 1'b1;
                    end
                end
                PH_WAIT:
                begin
                    if (slot_pos < timer_cap(t_pres_wait))
                    begin
                        slot_pos++;
                    end
                    else
                    begin
                        seq_phase = PH_WIN;
                        slot_pos  = 0;
                        again     = 1'b1;
                    end
                end
                PH_WIN:
                begin
                    if (slot_pos < timer_cap(t_pres_win))
                    begin
                        if (!lvl)
                        begin
                            presence_flag = 1'b1;
                        end
                        slot_pos++;
                    end
                    if (slot_pos >= timer_cap(t_pres_win))
                    begin
                        seq_phase = PH_IDLE;
                        slot_pos  = 0;
                        res.done  = 1'b1;
                    end
                end
                PH_WRITE:
                begin
                    low_len = timer_cap(shifter[0] ? t_one_low : t_zero_low);
                    res.drive_low = (slot_pos < low_len);
                    slot_pos++;
                    if (slot_pos >= slot_len)
                    begin
                        slot_pos = 0;
                        shifter  = shifter >> 1;
                        bit_pos  = (bit_pos + 1) % 8;
                        if (bit_pos == 0)
                        begin
                            seq_phase = PH_IDLE;
                            res.done  = 1'b1;
                        end
                    end
                end
                PH_READ:
                begin
                    samp = timer_cap(t_read_samp);
                    if (samp >= slot_len)
                    begin
                        samp = slot_len - 1;
                    end
                    res.drive_low = (slot_pos < timer_cap(t_read_low));
                    if (slot_pos == samp)
                    begin
                        shifter = {lvl, shifter[7:1]};
                    end
                    slot_pos++;
                    if (slot_pos >= slot_len)
                    begin
                        slot_pos = 0;
                        bit_pos  = (bit_pos + 1) % 8;
                        if (bit_pos == 0)
                        begin
                            last_byte = shifter;
                            seq_phase = PH_IDLE;
                            res.done  = 1'b1;
                        end
                    end
                end
                default:
                begin
                    seq_phase = PH_IDLE;
                end
            endcase
        end
        res.present   = presence_flag;
        res.read_data = last_byte;
    endtask

    // Compare one field of a result beat
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin : watch
        ow_result_t want;
        ow_result_t fresh;
        if (!rst_n)
        begin
            t_reset_low   = 10'd497;
            t_pres_wait   = 10'd61;
            t_pres_win    = 10'd480;
            t_one_low     = 10'd10;
            t_zero_low    = 10'd80;
            t_slot        = 10'd90;
            t_read_low    = 10'd1;
            t_read_samp   = 10'd10;
            seq_phase     = PH_IDLE;
            slot_pos      = 0;
            bit_pos       = 0;
            shifter       = 8'd0;
            presence_flag = 1'b0;
            last_byte     = 8'd0;
            expected_beats.delete();
        end
        else
        begin
            // Retire the oldest expectation against an accepted result beat
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    check_field("drive_low", 8'(want.drive_low), 8'(drive_low));
                    check_field("busy_res", 8'(want.busy), 8'(busy_res));
                    check_field("done_res", 8'(want.done), 8'(done_res));
                    check_field("device_present", 8'(want.present), 8'(device_present));
                    check_field("read_data", want.read_data, read_data);
                end
            end

            // Predict the result of an accepted tick beat
            if (in_valid && in_ready)
            begin
                step_bus_tick(ow_action_t'(action), data_byte, bus_level, fresh);
                expected_beats.push_back(fresh);
            end

            // Track register writes, masked to each register's width
            if (cfg_we)
            begin
                case (ow_cfg_idx_t'(cfg_index))
                    CFG_RESET_LOW:      t_reset_low = cfg_data;
                    CFG_PRESENCE_WAIT:  t_pres_wait = {2'd0, cfg_data[7:0]};
                    CFG_PRESENCE_WIN:   t_pres_win  = cfg_data;
                    CFG_WRITE_ONE_LOW:  t_one_low   = {4'd0, cfg_data[5:0]};
                    CFG_WRITE_ZERO_LOW: t_zero_low  = {2'd0, cfg_data[7:0]};
                    CFG_SLOT:           t_slot      = {2'd0, cfg_data[7:0]};
                    CFG_READ_LOW:       t_read_low  = {6'd0, cfg_data[3:0]};
                    default:            t_read_samp = {4'd0, cfg_data[5:0]};
                endcase
            end
        end
        backlog  = expected_beats.size();
        seq_idle = (seq_phase == PH_IDLE);
    end

endmodule

### dv/tb_one_wire_bus_master_top.sv
module tb_one_wire_bus_master_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ow_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 5000000;
    localparam int unsigned RAND_ITEMS  = 180;
    localparam int unsigned RAND_PHASES = 6;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [9:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        bus_level;
    logic        out_valid;
    logic        out_ready;
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        device_present;
    logic [7:0]  read_data;

    int unsigned fail_count;
    int unsigned backlog;
    logic        seq_idle;

    int unsigned cycle_count;
    int unsigned ticks_sent;
    int unsigned out_stall;
    bit          in_calm;
    bit          out_calm;

    one_wire_bus_master_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .data_byte      (data_byte),
        .bus_level      (bus_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .device_present (device_present),
        .read_data      (read_data)
    );

    ow_bus_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .data_byte      (data_byte),
        .bus_level      (bus_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .device_present (device_present),
        .read_data      (read_data),
        .fail_count     (fail_count),
        .backlog        (backlog),
        .seq_idle       (seq_idle)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles, flip the calm stretches, and stop a hung run
    initial
    begin
        cycle_count = 0;
        in_calm     = 1'b0;
        out_calm    = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0)
        begin
            in_calm  <= ($urandom_range(0, 3) == 0);
            out_calm <= ($urandom_range(0, 3) == 0);
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none in a calm stretch
    function automatic int unsigned draw_gap(input bit calm);
        int unsigned r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 24);
    endfunction

    // Stall the result channel at random
    initial
    begin
        out_ready = 1'b0;
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (out_stall > 0)
            begin
                out_ready <= 1'b0;
                out_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall = draw_gap(out_calm);
            end
        end
    end

    // Present one tick beat and hold it until accepted
    task automatic push_tick(input ow_action_t act, input logic [7:0] dat, input logic lvl);
        int unsigned gap;
        gap = draw_gap(in_calm);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= dat;
        bus_level <= lvl;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        ticks_sent++;
    endtask

    // Line level with the given share of low ticks in percent
    function automatic logic bus_draw(input int unsigned low_pct);
        return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
    endfunction

    // Issue a command, then tick until the sequence is back to idle
    task automatic run_command(input ow_action_t act, input logic [7:0] dat,
                               input int unsigned low_pct);
        ow_action_t noise;
        push_tick(act, dat, bus_draw(low_pct));
        while (!seq_idle)
        begin
            // Commands sent while busy must be ignored
            noise = ($urandom_range(0, 9) == 0) ? ow_action_t'(2'($urandom_range(1, 3)))
                                                : ACT_TICK;
            push_tick(noise, 8'($urandom), bus_draw(low_pct));
        end
    endtask

    // Drop valid and wait until every result beat has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (backlog != 0 || !seq_idle) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input ow_cfg_idx_t idx, input logic [9:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // Load a full timing set while the block is idle
    task automatic apply_timing(input logic [9:0] rst_low, input logic [9:0] pres_wait,
                                input logic [9:0] pres_win, input logic [9:0] one_low,
                                input logic [9:0] zero_low, input logic [9:0] slot,
                                input logic [9:0] rd_low, input logic [9:0] rd_samp);
        settle();
        write_reg(CFG_RESET_LOW, rst_low);
        write_reg(CFG_PRESENCE_WAIT, pres_wait);
        write_reg(CFG_PRESENCE_WIN, pres_win);
        write_reg(CFG_WRITE_ONE_LOW, one_low);
        write_reg(CFG_WRITE_ZERO_LOW, zero_low);
        write_reg(CFG_SLOT, slot);
        write_reg(CFG_READ_LOW, rd_low);
        write_reg(CFG_READ_SAMPLE, rd_samp);
        cfg_we <= 1'b0;
    endtask

    // Short random timings, zero included
    function automatic logic [9:0] pick_reg(input int unsigned upper);
        return 10'($urandom_range(0, upper));
    endfunction

    function automatic int unsigned pick_low_share();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 5;
            2:       return 50;
            3:       return 95;
            default: return 100;
        endcase
    endfunction

    initial
    begin
        int unsigned phase_start;
        int unsigned pick;
        ow_action_t  act;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        action     = ACT_TICK;
        data_byte  = '0;
        bus_level  = 1'b1;
        ticks_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default timings: bare ticks, then a write byte
        push_tick(ACT_TICK, 8'h00, 1'b0);
        push_tick(ACT_TICK, 8'hFF, 1'b1);
        run_command(ACT_WRITE, 8'hA5, 0);

        // Short timings: presence absent and present, extreme bytes
        apply_timing(10'd5, 10'd3, 10'd6, 10'd2, 10'd6, 10'd4, 10'd1, 10'd3);
        run_command(ACT_RESET, 8'h00, 0);
        run_command(ACT_RESET, 8'h00, 100);
        run_command(ACT_WRITE, 8'h00, 50);
        run_command(ACT_WRITE, 8'hFF, 50);
        run_command(ACT_READ, 8'h00, 0);
        run_command(ACT_READ, 8'hFF, 100);
        run_command(ACT_WRITE, 8'h01, 50);
        run_command(ACT_WRITE, 8'h80, 50);

        // All zero: reset completes at once, zero slot acts as one tick
        apply_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        run_command(ACT_RESET, 8'h00, 100);
        run_command(ACT_WRITE, 8'h5A, 50);
        run_command(ACT_READ, 8'h00, 50);

        // Pulses longer than the slot and a sample point past its end
        apply_timing(10'd1, 10'd0, 10'd1, 10'd63, 10'd255, 10'd4, 10'd15, 10'd63);
        run_command(ACT_WRITE, 8'h3C, 50);
        run_command(ACT_READ, 8'h00, 50);
        run_command(ACT_RESET, 8'h00, 100);

        // Upper bits of the data word set beyond the width of each narrower register
        apply_timing(10'd7, 10'h305, 10'd6, 10'h3C3, 10'h306, 10'h305, 10'h3F2,
                     10'h3C4);
        run_command(ACT_RESET, 8'h00, 30);
        run_command(ACT_WRITE, 8'hC3, 50);
        run_command(ACT_READ, 8'h00, 50);

        // Random timing sets with random command streams
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            apply_timing(pick_reg(12), pick_reg(6), pick_reg(12), pick_reg(10),
                         pick_reg(14), pick_reg(12), pick_reg(6), pick_reg(12));
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < RAND_ITEMS / RAND_PHASES)
            begin
                pick = $urandom_range(0, 9);
                act  = (pick == 0) ? ACT_TICK : ow_action_t'(2'(1 + pick % 3));
                run_command(act, 8'($urandom), pick_low_share());
            end
        end

        settle();
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
